>>> src/gcm_pkg.sv
`timescale 1ns / 1ps
package gcm_pkg;

  // number of denomination slots in use, 1 to 8
  localparam int NUM_DENOMS = 8;
  localparam int REG_COUNT  = 8;

  localparam int AMOUNT_W = 32;
  localparam int DENOM_W  = 24;
  localparam int SLOT_W   = 3;
  localparam int INDEX_W  = 8;
  localparam int CFG_W    = 32;
  localparam int STEP_W   = 5;

  localparam logic [SLOT_W-1:0] TOP_SLOT  = SLOT_W'(NUM_DENOMS - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = '0;

  typedef logic [DENOM_W-1:0] denom_t;

  // power-up denominations in cents, slot 0 first
  localparam denom_t DENOM_RESET [REG_COUNT] = '{
    24'd1, 24'd5, 24'd10, 24'd25, 24'd50, 24'd100, 24'd500, 24'd1000
  };

endpackage

>>> src/greedy_change_maker_unit.sv
`timescale 1ns / 1ps
// channel    | handshake                  | payload
// -----------+----------------------------+----------------------------------------------
// input item | start, busy (taken: !busy) | amount_cents
// result     | result_valid strobe        | slot_index, piece_count, leftover_cents,
//            |                            | last_result
// config     | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// per slot with a nonzero denomination: issue, divider steps, result; a zero slot gives
//   its result directly; busy stays high while the used slots are walked, paced by
//   the one radix-2 divider shared over all slots
// the next item is taken in the first idle cycle; a new item waits until busy drops
// reset: rst synchronous, restores the power-up denominations and idles the sequencer
// results are strobed for one cycle each, highest slot first; the receiver cannot stall
// busy stays high from the accepted item until the result for slot 0 is out
module greedy_change_maker_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [gcm_pkg::AMOUNT_W-1:0]  amount_cents,
  output logic                          result_valid,
  output logic [gcm_pkg::SLOT_W-1:0]    slot_index,
  output logic [gcm_pkg::AMOUNT_W-1:0]  piece_count,
  output logic [gcm_pkg::DENOM_W-1:0]   leftover_cents,
  output logic                          last_result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gcm_pkg::INDEX_W-1:0]   cfg_index,
  input  logic [gcm_pkg::CFG_W-1:0]     cfg_data
);
  import gcm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SLOT = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]          state;
  logic [SLOT_W-1:0]   slot;
  logic [AMOUNT_W-1:0] rest;

  denom_t              cur_denom;
  logic                div_go;
  logic                div_done;
  logic [AMOUNT_W-1:0] div_quo;
  denom_t              div_rem;
  logic                take;
  logic                wide_rest;

  // the user must let config writes land only while idle, the block does not enforce it; always ready
  assign cfg_ready = 1'b1;

  gcm_denom_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .rd_slot  (slot),
    .rd_denom (cur_denom)
  );

  // kick the divider for a slot with a real denomination
  assign div_go = (state == ST_SLOT) && (cur_denom != '0);

  gcm_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .done      (div_done),
    .dividend  (rest),
    .divisor   (cur_denom),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign busy      = (state != ST_IDLE);
  assign take      = start && !busy;
  assign wide_rest = (rest[AMOUNT_W-1:DENOM_W] != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (take) begin
            state <= ST_SLOT;
          end
        end
        ST_SLOT: begin
          if (cur_denom == '0) begin
            // unused slot: count zero, remainder passes through
            result_valid <= 1'b1;
            if (slot == LAST_SLOT) begin
              state <= ST_IDLE;
            end
          end else begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (div_done) begin
            result_valid <= 1'b1;
            state        <= (slot == LAST_SLOT) ? ST_IDLE : ST_SLOT;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath: running remainder, slot counter and the result registers
  always_ff @(posedge clk) begin
    if (take) begin
      rest <= amount_cents;
      slot <= TOP_SLOT;
    end else if ((state == ST_SLOT) && (cur_denom == '0)) begin
      slot_index     <= slot;
      piece_count    <= '0;
      leftover_cents <= wide_rest ? '1 : rest[DENOM_W-1:0];
      last_result    <= (slot == LAST_SLOT);
      slot           <= slot - SLOT_W'(1);
    end else if ((state == ST_WAIT) && div_done) begin
      rest           <= AMOUNT_W'(div_rem);
      slot_index     <= slot;
      piece_count    <= div_quo;
      leftover_cents <= div_rem;
      last_result    <= (slot == LAST_SLOT);
      slot           <= slot - SLOT_W'(1);
    end
  end

endmodule

>>> src/gcm_denom_regs.sv
`timescale 1ns / 1ps
module gcm_denom_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [gcm_pkg::INDEX_W-1:0]   wr_index,
  input  logic [gcm_pkg::CFG_W-1:0]     wr_data,
  input  logic [gcm_pkg::SLOT_W-1:0]    rd_slot,
  output gcm_pkg::denom_t               rd_denom
);
  import gcm_pkg::*;

  denom_t denom [REG_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < REG_COUNT; k++) begin
        denom[k] <= DENOM_RESET[k];
      end
    end else if (wr_en && (wr_index < INDEX_W'(REG_COUNT))) begin
      denom[wr_index[SLOT_W-1:0]] <= wr_data[DENOM_W-1:0];
    end
  end

  assign rd_denom = denom[rd_slot];

endmodule

>>> src/gcm_divider.sv
`timescale 1ns / 1ps
module gcm_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  output logic                          done,
  input  logic [gcm_pkg::AMOUNT_W-1:0]  dividend,
  input  gcm_pkg::denom_t               divisor,
  output logic [gcm_pkg::AMOUNT_W-1:0]  quotient,
  output gcm_pkg::denom_t               remainder
);
  import gcm_pkg::*;

  // restoring radix-2 divider, one quotient bit per cycle
  logic                  running;
  logic [STEP_W-1:0]     step;
  logic [DENOM_W:0]      part;
  logic [AMOUNT_W-1:0]   quo;
  denom_t                dsr;

  logic [DENOM_W:0]      shifted;
  logic [DENOM_W:0]      diff;
  logic                  fits;

  assign shifted = {part[DENOM_W-1:0], quo[AMOUNT_W-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        step    <= '1;
      end else if (running) begin
        step <= step - STEP_W'(1);
        if (step == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      part <= '0;
      quo  <= dividend;
      dsr  <= divisor;
    end else if (running) begin
      part <= fits ? diff : shifted;
      quo  <= {quo[AMOUNT_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = part[DENOM_W-1:0];

endmodule

>>> tb/greedy_change_maker_unit_tb.sv
`timescale 1ns / 1ps
module greedy_change_maker_unit_tb;
  import gcm_pkg::*;

  // clocking, reset and run bounds
  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 7;
  localparam int CYCLE_LIMIT     = 800000;
  localparam int SETTLE_CYCLES   = 300;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 60;

  // first register index the block must ignore
  localparam logic [INDEX_W-1:0] FIRST_BAD_INDEX = INDEX_W'(REG_COUNT);
  localparam logic [INDEX_W-1:0] TOP_BAD_INDEX   = '1;
  localparam denom_t DENOM_MAX = '1;

  // one slot of a split amount, as the block reports it
  typedef struct {
    logic [SLOT_W-1:0]   slot;
    logic [AMOUNT_W-1:0] pieces;
    logic [DENOM_W-1:0]  leftover;
    logic                last;
  } coin_slot_t;

  // keeps its own copy of the denominations and the slot results still owed
  class change_scoreboard;
    denom_t     denoms [REG_COUNT];
    coin_slot_t owed [$];
    int         mismatches;
    int         results_seen;

    function new();
      foreach (denoms[k]) denoms[k] = DENOM_RESET[k];
      mismatches   = 0;
      results_seen = 0;
    endfunction

    // only the low 24 bits are kept, out-of-range indexes are dropped
    function void set_denom(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx < REG_COUNT) denoms[idx] = data[DENOM_W-1:0];
    endfunction

    // greedy split, highest slot first, zero slot passes the remainder through
    function void note_amount(logic [AMOUNT_W-1:0] amount);
      logic [AMOUNT_W-1:0] rest;
      coin_slot_t          r;
      rest = amount;
      for (int s = NUM_DENOMS - 1; s >= 0; s--) begin
        r.slot   = SLOT_W'(s);
        r.pieces = '0;
        if (denoms[s] != '0) begin
          r.pieces = rest / AMOUNT_W'(denoms[s]);
          rest     = rest % AMOUNT_W'(denoms[s]);
        end
        // leftover port saturates, the full remainder carries on
        r.leftover = (rest > AMOUNT_W'(DENOM_MAX)) ? DENOM_MAX : rest[DENOM_W-1:0];
        r.last     = (s == 0);
        owed.insert(owed.size(), r);
      end
    endfunction

    task report_mismatch(string what, logic [AMOUNT_W-1:0] got,
                         logic [AMOUNT_W-1:0] want);
      mismatches++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task check_slot(coin_slot_t got);
      coin_slot_t want;
      results_seen++;
      if (owed.size() == 0) begin
        report_mismatch("unexpected result, slot_index", AMOUNT_W'(got.slot), '0);
        return;
      end
      want = owed.pop_front();
      if (got.slot !== want.slot)
        report_mismatch("slot_index", AMOUNT_W'(got.slot), AMOUNT_W'(want.slot));
      if (got.pieces !== want.pieces)
        report_mismatch("piece_count", got.pieces, want.pieces);
      if (got.leftover !== want.leftover)
        report_mismatch("leftover_cents", AMOUNT_W'(got.leftover),
                        AMOUNT_W'(want.leftover));
      if (got.last !== want.last)
        report_mismatch("last_result", AMOUNT_W'(got.last), AMOUNT_W'(want.last));
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [AMOUNT_W-1:0] amount_cents;
  logic                result_valid;
  logic [SLOT_W-1:0]   slot_index;
  logic [AMOUNT_W-1:0] piece_count;
  logic [DENOM_W-1:0]  leftover_cents;
  logic                last_result;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [INDEX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]    cfg_data;

  change_scoreboard sb = new();

  // run bookkeeping
  int  cycle_count  = 0;
  int  items_sent   = 0;
  int  cfg_writes   = 0;
  int  settings_run = 1;
  bit  back_to_back = 1'b0;

  // denomination plan for the next setting, slot 0 first
  denom_t              plan [REG_COUNT];
  logic [AMOUNT_W-1:0] amounts [$];

  greedy_change_maker_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .amount_cents   (amount_cents),
    .result_valid   (result_valid),
    .slot_index     (slot_index),
    .piece_count    (piece_count),
    .leftover_cents (leftover_cents),
    .last_result    (last_result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d slot results still owed",
               cycle_count, sb.owed.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // results are strobed for one cycle, grab them at the edge that ends it
  always @(posedge clk) begin : watch_results
    coin_slot_t seen;
    if (!rst && result_valid) begin
      seen.slot     = slot_index;
      seen.pieces   = piece_count;
      seen.leftover = leftover_cents;
      seen.last     = last_result;
      sb.check_slot(seen);
    end
  end

  // mostly no gap, some short ones, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (back_to_back || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 96) return $urandom_range(5, 40);
    return $urandom_range(100, 400);
  endfunction

  // small amounts dominate, full 32-bit ones keep every bit toggling
  function automatic logic [AMOUNT_W-1:0] random_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 5000);
    if (r < 70) return $urandom_range(0, 32'h00FF_FFFF);
    return $urandom();
  endfunction

  // realistic coin set: ascending, with an occasional unused slot
  function automatic void fill_sorted_plan();
    int unsigned prev;
    int unsigned step;
    prev = 0;
    foreach (plan[k]) begin
      if ($urandom_range(0, 5) == 0) begin
        plan[k] = '0;
      end else begin
        step = $urandom_range(1, prev * 2 + 9);
        prev = (prev + step > DENOM_MAX) ? DENOM_MAX : prev + step;
        plan[k] = DENOM_W'(prev);
      end
    end
  endfunction

  // anything goes: unsorted, zeros, full-scale values
  function automatic void fill_wild_plan();
    int r;
    foreach (plan[k]) begin
      r = $urandom_range(0, 99);
      if (r < 20)      plan[k] = '0;
      else if (r < 30) plan[k] = DENOM_MAX;
      else if (r < 60) plan[k] = DENOM_W'($urandom_range(1, 200));
      else             plan[k] = DENOM_W'($urandom());
    end
  endfunction

  // sender gap; start drops at the first falling edge and stays low
  task automatic pause(int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // start stays up across back-to-back items, taken when busy is low
  task automatic send_amount(logic [AMOUNT_W-1:0] amount);
    @(negedge clk);
    start        <= 1'b1;
    amount_cents <= amount;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_amount(amount);
    items_sent++;
  endtask

  task automatic send_list();
    foreach (amounts[k]) begin
      send_amount(amounts[k]);
      pause(gap_len());
    end
  endtask

  // let every owed result out and the block go idle before touching registers
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
    repeat ($urandom_range(0, 3)) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_denom(idx, data);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // junk in the upper byte must be dropped by the block
  task automatic write_plan();
    foreach (plan[k])
      write_reg(INDEX_W'(k), {8'($urandom()), plan[k]});
    settings_run++;
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    amount_cents = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // power-up coin set: zero, ones, exact hits, full scale, bit patterns
    amounts = '{32'd0, 32'd1, 32'd4, 32'd5, 32'd99, 32'd1888, 32'hFFFF_FFFF,
                32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
    send_list();
    drain();

    // every slot unused: counts all zero, leftover saturates on every slot for the wide amounts
    plan = '{default: '0};
    write_plan();
    // writes past the last register must not land anywhere
    write_reg(FIRST_BAD_INDEX, 32'hFFFF_FFFF);
    write_reg(TOP_BAD_INDEX, 32'h1234_5678);
    amounts = '{32'h00FF_FFFF, 32'h0100_0000, 32'hFFFF_FFFF, 32'd7};
    send_list();
    drain();

    // largest denominations everywhere
    plan = '{default: DENOM_MAX};
    write_plan();
    amounts = '{32'hFFFF_FFFF, 32'd16777214, 32'd16777215};
    send_list();
    drain();

    // unsorted with holes, empty top slot so the wide leftover shows up
    plan = '{24'd2, 24'd0, 24'd9, 24'd3, 24'd0, 24'd700, 24'd13, 24'd0};
    write_plan();
    amounts = '{32'hFFFF_FFFF, 32'd12345};
    send_list();
    drain();

    // smallest nonzero value in every slot, whole amount lands on the top slot
    plan = '{default: 24'd1};
    write_plan();
    amounts = '{32'hFFFF_FFFF};
    send_list();
    drain();

    // random phases, mostly sensible coin sets, some wild ones
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p % 3 == 2) fill_wild_plan();
      else            fill_sorted_plan();
      write_plan();
      if ($urandom_range(0, 1) == 1)
        write_reg(INDEX_W'($urandom_range(REG_COUNT, 255)), $urandom());
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // switch between stretches of back-to-back items and gappy ones
        if (i % 15 == 0) back_to_back = ($urandom_range(0, 3) == 0);
        send_amount(random_amount());
        pause(gap_len());
      end
      back_to_back = 1'b0;
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d amounts under %0d coin sets, %0d register writes",
             items_sent, settings_run, cfg_writes);
    $display("checked %0d slot results, %0d mismatches", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
